/* design/brace_aware_statement_splitter_assert.svh */
// Assertion macros for the statement splitter.
// Used by brace_aware_statement_splitter.sv; expects clk and rst_n in scope.
`ifndef BRACE_AWARE_STATEMENT_SPLITTER_ASSERT_SVH
`define BRACE_AWARE_STATEMENT_SPLITTER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BAS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splitter check failed");
// next-cycle implication
`define BAS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splitter check failed");
`else
`define BAS_ASSERT_IMP(name, ante, cons)
`define BAS_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* design/bas_pkg.sv */
// Scan modes and character codes for the statement splitter.
// No dependencies.
package bas_pkg;

  typedef enum logic [3:0] {
    MODE_CODE,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR,
    MODE_STR,
    MODE_ESC,
    MODE_TRAIL,
    MODE_SKIP
  } mode_t;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

/* design/brace_aware_statement_splitter.sv */
// Top-level statement splitter: scan state, boundary logic, result queue.
// Depends on bas_pkg and brace_aware_statement_splitter_assert.svh.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  text_byte, end_of_text
//   out_     output     out_valid/out_stall stmt_valid, stmt_begin, stmt_stop,
//                                          first_line, final_line, run_last,
//                                          text_done
//
// One byte is taken per cycle while in_stall is low; its scan update and its
// results are settled in the same cycle and land in a four-entry result queue.
// A byte that gives two results hands them out one at a time; the queue
// absorbs that, and in_stall rises only while more than two results wait.
// Synchronous active-low reset clears the scan state and empties the queue.
// A stall on the output holds the head request stable.
`include "brace_aware_statement_splitter_assert.svh"

module brace_aware_statement_splitter
  import bas_pkg::*;
#(
  parameter int DEPTH_MAX   = 255,
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_end_of_text,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_stmt_valid,
  output logic [OFFSET_BITS-1:0] out_stmt_begin,
  output logic [OFFSET_BITS-1:0] out_stmt_stop,
  output logic [LINE_BITS-1:0]   out_first_line,
  output logic [LINE_BITS-1:0]   out_final_line,
  output logic                   out_run_last,
  output logic                   out_text_done
);

  localparam int DW = $clog2(DEPTH_MAX + 1);
  localparam logic [DW-1:0] DEPTH_TOP = DW'(DEPTH_MAX);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LN_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LN_ONE  = LINE_BITS'(1);

  typedef struct packed {
    logic                   stmt_valid;
    logic [OFFSET_BITS-1:0] stmt_begin;
    logic [OFFSET_BITS-1:0] stmt_stop;
    logic [LINE_BITS-1:0]   first_line;
    logic [LINE_BITS-1:0]   final_line;
    logic                   run_last;
    logic                   text_done;
  } res_t;

  // scan state
  mode_t                  mode_r, mode_nxt;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] spos_r, spos_nxt;
  logic [LINE_BITS-1:0]   sline_r, sline_nxt;
  logic                   saw_r, saw_nxt;

  // result queue
  res_t       fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  logic in_fire, out_fire;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = count_r > 3'd2;
  assign out_valid = count_r != 3'd0;

  // working copies for the byte update
  logic [7:0]             c;
  logic                   is_ws;
  logic [OFFSET_BITS-1:0] next_pos;
  mode_t                  mode_v;
  logic [DW-1:0]          depth_v;
  logic [LINE_BITS-1:0]   line_v;
  logic [OFFSET_BITS-1:0] spos_v;
  logic [LINE_BITS-1:0]   sline_v;
  logic                   saw_v;
  logic                   do_skip, do_stmt, do_code;
  logic                   main_emit, eot_emit;
  res_t                   main_res, eot_res, slot0, slot1;
  logic [1:0]             push_n;

  assign c        = in_text_byte;
  assign is_ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign next_pos = (pos_r < OFF_MAX) ? pos_r + 1'b1 : OFF_MAX;

  // per-byte scan: trail, skip, statement body, then code characters
  always_comb begin
    mode_v    = mode_r;
    depth_v   = depth_r;
    line_v    = line_r;
    spos_v    = spos_r;
    sline_v   = sline_r;
    saw_v     = saw_r;
    do_skip   = 1'b0;
    do_stmt   = 1'b0;
    do_code   = 1'b0;
    main_emit = 1'b0;
    main_res  = '0;

    // after a closing brace: same-line spaces and one semicolon belong
    if (mode_r == MODE_TRAIL) begin
      if (c == CH_LF || !is_ws) begin
        mode_v    = MODE_SKIP;
        saw_v     = 1'b0;
        main_emit = 1'b1;
        main_res.stmt_valid = 1'b1;
        main_res.stmt_begin = spos_v;
        main_res.first_line = sline_v;
        main_res.final_line = line_v;
        if (c == CH_SEMI) begin
          main_res.stmt_stop = next_pos;
        end else begin
          main_res.stmt_stop = pos_r;
          do_skip = 1'b1;
        end
      end
    end else if (mode_r == MODE_SKIP) begin
      do_skip = 1'b1;
    end else begin
      do_stmt = 1'b1;
    end

    // whitespace between statements
    if (do_skip) begin
      if (is_ws) begin
        if (c == CH_LF && line_v < LN_MAX) line_v = line_v + 1'b1;
      end else begin
        spos_v  = pos_r;
        sline_v = line_v;
        saw_v   = 1'b0;
        mode_v  = MODE_CODE;
        do_stmt = 1'b1;
      end
    end

    // comments, strings and lookahead
    if (do_stmt) begin
      if (!is_ws) saw_v = 1'b1;
      if (mode_v == MODE_ESC) begin
        mode_v = MODE_STR;
      end else if (c == CH_LF) begin
        if (line_v < LN_MAX) line_v = line_v + 1'b1;
        if (mode_v == MODE_LINE || mode_v == MODE_SLASH) mode_v = MODE_CODE;
        else if (mode_v == MODE_BSTAR) mode_v = MODE_BLOCK;
      end else begin
        case (mode_v)
          MODE_LINE: ;
          MODE_BLOCK: begin
            if (c == CH_STAR) mode_v = MODE_BSTAR;
          end
          MODE_BSTAR: begin
            if (c == CH_SLASH) mode_v = MODE_CODE;
            else if (c != CH_STAR) mode_v = MODE_BLOCK;
          end
          MODE_STR: begin
            if (c == CH_BSLASH) mode_v = MODE_ESC;
            else if (c == CH_QUOTE) mode_v = MODE_CODE;
          end
          MODE_SLASH: begin
            if (c == CH_SLASH) mode_v = MODE_LINE;
            else if (c == CH_STAR) mode_v = MODE_BLOCK;
            else begin
              mode_v  = MODE_CODE;
              do_code = 1'b1;
            end
          end
          default: begin
            mode_v  = MODE_CODE;
            do_code = 1'b1;
          end
        endcase
      end
    end

    // plain code: nesting and statement ends
    if (do_code) begin
      case (c)
        CH_SLASH: mode_v = MODE_SLASH;
        CH_QUOTE: mode_v = MODE_STR;
        CH_LBRACE, CH_LPAREN: begin
          if (depth_v < DEPTH_TOP) depth_v = depth_v + 1'b1;
        end
        CH_RPAREN: begin
          if (depth_v != '0) depth_v = depth_v - 1'b1;
        end
        CH_RBRACE: begin
          if (depth_v <= DW'(1)) begin
            depth_v = '0;
            mode_v  = MODE_TRAIL;
          end else begin
            depth_v = depth_v - 1'b1;
          end
        end
        CH_SEMI: begin
          if (depth_v == '0) begin
            main_emit = 1'b1;
            main_res.stmt_valid = 1'b1;
            main_res.stmt_begin = spos_v;
            main_res.stmt_stop  = next_pos;
            main_res.first_line = sline_v;
            main_res.final_line = line_v;
            mode_v = MODE_SKIP;
            saw_v  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // end of text: flush remainder, build queue entries, reset the scan
  always_comb begin
    eot_emit = in_end_of_text &&
               (mode_v == MODE_TRAIL || (mode_v != MODE_SKIP && saw_v));
    eot_res = '0;
    eot_res.stmt_valid = 1'b1;
    eot_res.stmt_begin = spos_v;
    eot_res.stmt_stop  = next_pos;
    eot_res.first_line = sline_v;
    eot_res.final_line = line_v;

    slot0 = main_emit ? main_res : (eot_emit ? eot_res : res_t'('0));
    slot1 = eot_res;
    if (!in_end_of_text) push_n = {1'b0, main_emit};
    else if (main_emit && eot_emit) push_n = 2'd2;
    else push_n = 2'd1;

    if (push_n == 2'd2) begin
      slot1.run_last  = 1'b1;
      slot1.text_done = 1'b1;
    end else begin
      slot0.run_last  = 1'b1;
      slot0.text_done = in_end_of_text;
    end

    if (in_end_of_text) begin
      mode_nxt  = MODE_CODE;
      depth_nxt = '0;
      line_nxt  = LN_ONE;
      pos_nxt   = '0;
      spos_nxt  = '0;
      sline_nxt = LN_ONE;
      saw_nxt   = 1'b0;
    end else begin
      mode_nxt  = mode_v;
      depth_nxt = depth_v;
      line_nxt  = line_v;
      pos_nxt   = next_pos;
      spos_nxt  = spos_v;
      sline_nxt = sline_v;
      saw_nxt   = saw_v;
    end
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CODE;
      depth_r <= '0;
      line_r  <= LN_ONE;
      pos_r   <= '0;
      spos_r  <= '0;
      sline_r <= LN_ONE;
      saw_r   <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      line_r  <= line_nxt;
      pos_r   <= pos_nxt;
      spos_r  <= spos_nxt;
      sline_r <= sline_nxt;
      saw_r   <= saw_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_fire && push_n != 2'd0) fifo_r[wr_ptr_r] <= slot0;
    if (in_fire && push_n == 2'd2) fifo_r[wr_ptr_r + 2'd1] <= slot1;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + push_n;
      if (out_fire) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + (in_fire ? {1'b0, push_n} : 3'd0)
                 - {2'b0, out_fire};
    end
  end

  res_t head;
  assign head           = fifo_r[rd_ptr_r];
  assign out_stmt_valid = head.stmt_valid;
  assign out_stmt_begin = head.stmt_begin;
  assign out_stmt_stop  = head.stmt_stop;
  assign out_first_line = head.first_line;
  assign out_final_line = head.final_line;
  assign out_run_last   = head.run_last;
  assign out_text_done  = head.text_done;

  // checks
  `BAS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= 3'd4)
  `BAS_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DEPTH_TOP)
  `BAS_ASSERT_NXT(a_eot_resets, in_fire && in_end_of_text, pos_r == '0 && depth_r == '0 && line_r == LN_ONE)
  `BAS_ASSERT_NXT(a_pop_only, out_fire && !in_fire, count_r == $past(count_r) - 3'd1)
  `BAS_ASSERT_IMP(a_done_is_last, out_valid && out_text_done, out_run_last)

endmodule
